/* hdl/nwt_pkg.sv */
`default_nettype none

package nwt_pkg;

    localparam int unsigned VALUE_WIDTH = 31;
    localparam int unsigned WORD_WIDTH  = 5;

    // binary-to-decimal register: four groups of three digits
    localparam int unsigned DIGITS      = 12;
    localparam int unsigned BCD_BITS    = 4 * DIGITS;
    localparam int unsigned GROUP_BITS  = 12;
    localparam int unsigned REST_BITS   = BCD_BITS - GROUP_BITS;

    localparam logic [WORD_WIDTH-1:0] W_ZERO    = 5'd0;
    localparam logic [WORD_WIDTH-1:0] W_TEN     = 5'd10;
    localparam logic [WORD_WIDTH-1:0] W_TENS_BASE = 5'd18;
    localparam logic [WORD_WIDTH-1:0] W_HUNDRED = 5'd28;

    localparam logic [1:0] TOP_GROUP = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CONV  = 7'b0000010,
        ST_HUND  = 7'b0000100,
        ST_HWORD = 7'b0001000,
        ST_TENS  = 7'b0010000,
        ST_ONES  = 7'b0100000,
        ST_SCALE = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

/* hdl/nwt_if.sv */
`default_nettype none

interface nwt_value_if;
    logic                                   valid;
    logic                                   ready;
    logic [nwt_pkg::VALUE_WIDTH-1:0]        value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface nwt_word_if;
    logic                                   valid;
    logic                                   ready;
    logic [nwt_pkg::WORD_WIDTH-1:0]         word;
    logic                                   last;

    modport source (output valid, output word, output last, input ready);
    modport sink   (input valid, input word, input last, output ready);
endinterface

`default_nettype wire

/* hdl/number_to_word_tokens_core.sv */
`default_nettype none

// Spells a non-negative integer as a run of English word codes, most significant
// group first, with last set on the final word. The value is first turned into
// decimal digits one input bit per cycle (shift-and-add-3), then a sequencer
// walks the four three-digit groups word position by word position (hundreds
// digit, Hundred, tens, ones, scale), skipping a group that is zero in one step.
// A stalled output holds the sequencer. A new value is taken once the previous
// run has been handed to the output register.
module number_to_word_tokens_core #(
    parameter int unsigned VALUE_BITS = 31
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    nwt_value_if.sink    i_in,
    nwt_word_if.source   o_out
);

    localparam int unsigned CNT_BITS = $clog2(VALUE_BITS);

    nwt_pkg::t_state                        r_state, n_state;
    logic [VALUE_BITS-1:0]                  r_bin, n_bin;
    logic [nwt_pkg::BCD_BITS-1:0]           r_bcd, n_bcd;
    logic [nwt_pkg::BCD_BITS-1:0]           bcd_adj;
    logic [CNT_BITS-1:0]                    r_cnt, n_cnt;
    logic [1:0]                             r_grp, n_grp;
    logic                                   r_out_valid, n_out_valid;
    logic [nwt_pkg::WORD_WIDTH-1:0]         r_word, n_word;
    logic                                   r_last, n_last;

    logic                                   advance;
    logic [3:0]                             dig_h, dig_t, dig_o;
    logic                                   rest_zero, grp_zero, has_scale;
    logic                                   tens_word, ones_nz;
    logic [nwt_pkg::WORD_WIDTH-1:0]         ones_val;

    // add-3 correction on every digit
    always_comb begin
        for (int d = 0; d < nwt_pkg::DIGITS; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    assign dig_h     = r_bcd[nwt_pkg::BCD_BITS-1 -: 4];
    assign dig_t     = r_bcd[nwt_pkg::BCD_BITS-5 -: 4];
    assign dig_o     = r_bcd[nwt_pkg::BCD_BITS-9 -: 4];
    assign rest_zero = (r_bcd[nwt_pkg::REST_BITS-1:0] == '0);
    assign grp_zero  = (r_bcd[nwt_pkg::BCD_BITS-1 -: nwt_pkg::GROUP_BITS] == '0);
    assign has_scale = (r_grp != 2'd0);
    assign tens_word = (dig_t >= 4'd2);
    assign ones_val  = (dig_t == 4'd1) ? nwt_pkg::W_TEN + {1'b0, dig_o} : {1'b0, dig_o};
    assign ones_nz   = tens_word ? (dig_o != 4'd0) : (ones_val != '0);

    assign advance   = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_grp       = r_grp;
        n_out_valid = r_out_valid && !o_out.ready;
        n_word      = r_word;
        n_last      = r_last;

        case (r_state)
            nwt_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_bin   = i_in.value[VALUE_BITS-1:0];
                    n_bcd   = '0;
                    n_cnt   = CNT_BITS'(VALUE_BITS - 1);
                    n_state = nwt_pkg::ST_CONV;
                end
            end
            nwt_pkg::ST_CONV: begin
                n_bcd = {bcd_adj[nwt_pkg::BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                n_grp = nwt_pkg::TOP_GROUP;
                if (r_cnt == '0) begin
                    n_state = nwt_pkg::ST_HUND;
                end
            end
            nwt_pkg::ST_HUND: begin
                if (advance) begin
                    if (r_bcd == '0) begin
                        n_out_valid = 1'b1;
                        n_word      = nwt_pkg::W_ZERO;
                        n_last      = 1'b1;
                        n_state     = nwt_pkg::ST_IDLE;
                    end else if (grp_zero) begin
                        n_bcd = {r_bcd[nwt_pkg::REST_BITS-1:0],
                                 {nwt_pkg::GROUP_BITS{1'b0}}};
                        n_grp = r_grp - 1'b1;
                    end else if (dig_h != 4'd0) begin
                        n_out_valid = 1'b1;
                        n_word      = {1'b0, dig_h};
                        n_last      = 1'b0;
                        n_state     = nwt_pkg::ST_HWORD;
                    end else begin
                        n_state = nwt_pkg::ST_TENS;
                    end
                end
            end
            nwt_pkg::ST_HWORD: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    n_word      = nwt_pkg::W_HUNDRED;
                    n_last      = !tens_word && !ones_nz && !has_scale && rest_zero;
                    n_state     = n_last ? nwt_pkg::ST_IDLE : nwt_pkg::ST_TENS;
                end
            end
            nwt_pkg::ST_TENS: begin
                if (advance) begin
                    n_state = nwt_pkg::ST_ONES;
                    if (tens_word) begin
                        n_out_valid = 1'b1;
                        n_word      = nwt_pkg::W_TENS_BASE + {1'b0, dig_t};
                        n_last      = !ones_nz && !has_scale && rest_zero;
                        if (n_last) begin
                            n_state = nwt_pkg::ST_IDLE;
                        end
                    end
                end
            end
            nwt_pkg::ST_ONES: begin
                if (advance) begin
                    n_state = nwt_pkg::ST_SCALE;
                    if (ones_nz) begin
                        n_out_valid = 1'b1;
                        n_word      = ones_val;
                        n_last      = !has_scale && rest_zero;
                        if (n_last) begin
                            n_state = nwt_pkg::ST_IDLE;
                        end
                    end
                end
            end
            nwt_pkg::ST_SCALE: begin
                if (advance) begin
                    n_state = nwt_pkg::ST_HUND;
                    n_bcd   = {r_bcd[nwt_pkg::REST_BITS-1:0],
                               {nwt_pkg::GROUP_BITS{1'b0}}};
                    n_grp   = r_grp - 1'b1;
                    if (has_scale) begin
                        n_out_valid = 1'b1;
                        n_word      = nwt_pkg::W_HUNDRED + {3'b000, r_grp};
                        n_last      = rest_zero;
                        if (n_last) begin
                            n_state = nwt_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = nwt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nwt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_grp  <= n_grp;
        r_word <= n_word;
        r_last <= n_last;
    end

    assign i_in.ready  = (r_state == nwt_pkg::ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.word  = r_word;
    assign o_out.last  = r_last;

endmodule

`default_nettype wire

/* tb/nwt_spelling_checker.sv */
`timescale 1ns / 1ps

module nwt_spelling_checker (
    input  wire     i_clk,
    input  wire     i_rst_n,
    nwt_value_if    i_in_mon,
    nwt_word_if     i_out_mon,
    output int      o_errors,
    output int      o_pending,
    output int      o_words
);

    typedef struct packed {
        logic [nwt_pkg::WORD_WIDTH-1:0] word;
        logic                           last;
    } t_word_tok;

    t_word_tok expected_words[$];
    int mismatch_count = 0;
    int word_count     = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = expected_words.size();
    assign o_words   = word_count;

    // english spelling of one value as word codes, most significant group first
    function automatic void spell_value(input logic [nwt_pkg::VALUE_WIDTH-1:0] value);
        int unsigned                    groups[4];
        int unsigned                    rest;
        logic [nwt_pkg::WORD_WIDTH-1:0] run[$];
        int                             g;
        if (value == '0) begin
            run.push_back(nwt_pkg::W_ZERO);
        end else begin
            groups[0] = value % 1000;
            groups[1] = (value / 1000) % 1000;
            groups[2] = (value / 1000000) % 1000;
            groups[3] = (value / 1000000000) % 1000;
            for (g = 3; g >= 0; g--) begin
                if (groups[g] != 0) begin
                    rest = groups[g] % 100;
                    if (groups[g] >= 100) begin
                        run.push_back(nwt_pkg::WORD_WIDTH'(groups[g] / 100));
                        run.push_back(nwt_pkg::W_HUNDRED);
                    end
                    if (rest >= 20) begin
                        run.push_back(nwt_pkg::W_TENS_BASE +
                                      nwt_pkg::WORD_WIDTH'(rest / 10));
                        rest = rest % 10;
                    end
                    if (rest != 0) begin
                        run.push_back(nwt_pkg::WORD_WIDTH'(rest));
                    end
                    // thousand, million, billion follow hundred
                    if (g != 0) begin
                        run.push_back(nwt_pkg::W_HUNDRED + nwt_pkg::WORD_WIDTH'(g));
                    end
                end
            end
        end
        foreach (run[i]) begin
            expected_words.push_back(t_word_tok'{run[i], i == run.size() - 1});
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_word_tok exp_tok;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                spell_value(i_in_mon.value);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                word_count++;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected item word %0d last %0b", $time,
                             i_out_mon.word, i_out_mon.last);
                    mismatch_count++;
                end else begin
                    exp_tok = expected_words.pop_front();
                    if (i_out_mon.word !== exp_tok.word) begin
                        $display("%0t: word mismatch expected %0d actual %0d", $time,
                                 exp_tok.word, i_out_mon.word);
                        mismatch_count++;
                    end
                    if (i_out_mon.last !== exp_tok.last) begin
                        $display("%0t: last mismatch expected %0b actual %0b", $time,
                                 exp_tok.last, i_out_mon.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_number_to_word_tokens_core.sv */
`timescale 1ns / 1ps

module tb_number_to_word_tokens_core;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct = 23;
    int recv_idle_pct = 75;
    int values_sent   = 0;
    int mismatch_count;
    int pending_words;
    int words_seen;
    int drain_cycles;
    int phase;

    int unsigned directed_values [25] = '{
        0, 1, 9, 10, 11, 15, 19, 20, 21, 45, 99, 100, 101, 110, 999, 1000, 1001,
        20000, 1000000, 1000000000, 1010101010, 777777777, 1999999999,
        2147483647, 1073741824
    };

    nwt_value_if value_ch ();
    nwt_word_if  word_ch ();

    number_to_word_tokens_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (value_ch),
        .o_out   (word_ch)
    );

    nwt_spelling_checker spelling_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_mon  (value_ch),
        .i_out_mon (word_ch),
        .o_errors  (mismatch_count),
        .o_pending (pending_words),
        .o_words   (words_seen)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        word_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [nwt_pkg::VALUE_WIDTH-1:0] random_value();
        longint unsigned v;
        longint unsigned scale;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            // sparse thousand groups, some of them zero
            v = $urandom_range(2);
            repeat (3) v = v * 1000 + (($urandom_range(3) == 0) ? 0 : $urandom_range(999));
            if (v > 64'h7fffffff) v = v - 1000000000;
        end else if (pick < 60) begin
            v = $urandom_range(999);
        end else if (pick < 85) begin
            v = $urandom & 32'h7fffffff;
        end else begin
            case ($urandom_range(3))
                0: scale = 1;
                1: scale = 1000;
                2: scale = 1000000;
                default: scale = 1000000000;
            endcase
            v = scale * $urandom_range(1, 2) + $urandom_range(2) - 1;
        end
        return nwt_pkg::VALUE_WIDTH'(v);
    endfunction

    task automatic send_value(input logic [nwt_pkg::VALUE_WIDTH-1:0] v);
        int gap;
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        do @(posedge i_clk); while (!value_ch.ready);
        values_sent++;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            value_ch.valid <= 1'b0;
            value_ch.value <= nwt_pkg::VALUE_WIDTH'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        value_ch.valid <= 1'b0;
        value_ch.value <= '0;
        i_rst_n        <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[i]) begin
            send_value(nwt_pkg::VALUE_WIDTH'(directed_values[i]));
        end

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 23 : 0;
            repeat (145) send_value(random_value());
        end
        value_ch.valid <= 1'b0;
        @(posedge i_clk);

        drain_cycles = 0;
        while (pending_words != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (60) @(posedge i_clk);

        if (pending_words != 0) begin
            $display("%0t: %0d expected words never arrived", $time, pending_words);
        end
        $display("%0d values spelled: zero, teens, tens, scale edges, sparse groups, 31-bit max",
                 values_sent);
        $display("%0d word items checked with idling 23/75, 75/23 and none", words_seen);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
